>>> design/csst_pkg.sv
// Shared constants, types and helpers for the comment and string span tokenizer.
// Has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none
package csst_pkg;

  localparam int CHAR_BITS = 16;
  localparam int POS_BITS  = 16;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [CHAR_BITS-1:0] CH_SLASH = CHAR_BITS'(8'h2F);
  localparam logic [CHAR_BITS-1:0] CH_STAR  = CHAR_BITS'(8'h2A);
  localparam logic [CHAR_BITS-1:0] CH_QUOTE = CHAR_BITS'(8'h22);

  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_COMMENT = 2'd1;
  localparam logic [1:0] MODE_STRING  = 2'd2;

  localparam logic [2:0] KIND_PLAIN_BODY    = 3'd0;
  localparam logic [2:0] KIND_COMMENT_OPEN  = 3'd1;
  localparam logic [2:0] KIND_COMMENT_CLOSE = 3'd2;
  localparam logic [2:0] KIND_COMMENT_BODY  = 3'd3;
  localparam logic [2:0] KIND_STRING_OPEN   = 3'd4;
  localparam logic [2:0] KIND_STRING_CLOSE  = 3'd5;
  localparam logic [2:0] KIND_STRING_BODY   = 3'd6;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  typedef struct packed {
    logic [2:0]          kind;
    logic [POS_BITS-1:0] span_begin;
    logic [POS_BITS-1:0] span_end;
    logic                last;
  } span_t;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] p);
    sat_inc = (p == POS_MAX) ? p : p + POS_BITS'(1);
  endfunction

endpackage
`default_nettype wire

>>> design/comment_string_span_tokenizer.sv
// Top level of the comment and string span tokenizer: lexer state and result queue.
// Depends on csst_pkg.
`timescale 1ns / 1ps
`default_nettype none
// The input channel carries one item per transfer: a character of the current
// line (in_action low) or an end-of-line marker (in_action high). The result
// channel carries spans as kind, begin, end and a last flag that marks the
// final span caused by one input item; an item causes zero, one or two spans.
// The lexer state is updated in the cycle of the input transfer and the spans
// of that item are written into a four-entry result queue, which offers them
// in order on the result channel. The block
// takes one input item per cycle as long as the queue has room for two spans;
// the queue drains one span per cycle, so items that cause two spans are
// limited by the result channel to one span per cycle. When the receiver
// stalls, the queue fills and in_ready falls once fewer than two entries are
// free. A synchronous active-low reset empties the queue and returns the
// lexer to plain mode at position zero with nothing held.
module comment_string_span_tokenizer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_action,
  input  wire logic [csst_pkg::CHAR_BITS-1:0] in_character,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_span_kind,
  output logic [csst_pkg::POS_BITS-1:0]      out_span_begin,
  output logic [csst_pkg::POS_BITS-1:0]      out_span_end,
  output logic                               out_last_of_run
);
  import csst_pkg::*;

  logic [1:0]          mode_r, mode_nxt;
  logic                held_r, held_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] last_r, last_nxt;

  span_t      queue_r [4];
  logic [1:0] head_r, tail_r;
  logic [2:0] count_r, count_nxt;

  logic                accept, pop;
  logic                body_v, mark_v;
  logic [POS_BITS-1:0] flush_end, mark_begin, p_dec, p_inc;
  logic [2:0]          body_kind, mark_kind;
  span_t               body_s, mark_s;
  logic [1:0]          push_n;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;
  assign p_dec  = (pos_r == '0) ? pos_r : pos_r - POS_BITS'(1);
  assign p_inc  = sat_inc(pos_r);

  always_comb begin
    case (mode_r)
      MODE_COMMENT: body_kind = KIND_COMMENT_BODY;
      MODE_STRING:  body_kind = KIND_STRING_BODY;
      default:      body_kind = KIND_PLAIN_BODY;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    held_nxt   = 1'b0;
    pos_nxt    = p_inc;
    last_nxt   = last_r;
    mark_v     = 1'b0;
    mark_kind  = KIND_PLAIN_BODY;
    mark_begin = pos_r;
    flush_end  = pos_r;
    if (in_action == ACT_EOL) begin
      pos_nxt  = '0;
      last_nxt = '0;
    end else if (held_r && mode_r == MODE_COMMENT && in_character == CH_SLASH) begin
      flush_end  = p_dec;
      mark_v     = 1'b1;
      mark_kind  = KIND_COMMENT_CLOSE;
      mark_begin = p_dec;
      mode_nxt   = MODE_PLAIN;
    end else if (held_r && mode_r != MODE_COMMENT && mode_r != MODE_STRING &&
                 in_character == CH_STAR) begin
      flush_end  = p_dec;
      mark_v     = 1'b1;
      mark_kind  = KIND_COMMENT_OPEN;
      mark_begin = p_dec;
      mode_nxt   = MODE_COMMENT;
    end else if (mode_r == MODE_STRING) begin
      if (in_character == CH_QUOTE) begin
        mark_v    = 1'b1;
        mark_kind = KIND_STRING_CLOSE;
        mode_nxt  = MODE_PLAIN;
      end
    end else if (mode_r == MODE_COMMENT) begin
      held_nxt = (in_character == CH_STAR);
    end else begin
      if (in_character == CH_QUOTE) begin
        mark_v    = 1'b1;
        mark_kind = KIND_STRING_OPEN;
        mode_nxt  = MODE_STRING;
      end else begin
        held_nxt = (in_character == CH_SLASH);
      end
    end
    body_v = (in_action == ACT_EOL || mark_v) && (last_r < flush_end);
    if (mark_v && in_action != ACT_EOL) begin
      last_nxt = p_inc;
    end
  end

  always_comb begin
    body_s.kind       = body_kind;
    body_s.span_begin = last_r;
    body_s.span_end   = flush_end;
    body_s.last       = !mark_v;
    mark_s.kind       = mark_kind;
    mark_s.span_begin = mark_begin;
    mark_s.span_end   = p_inc;
    mark_s.last       = 1'b1;
    push_n            = {1'b0, body_v} + {1'b0, mark_v};
    count_nxt         = count_r;
    if (accept) begin
      count_nxt = count_nxt + {1'b0, push_n};
    end
    if (pop) begin
      count_nxt = count_nxt - 3'd1;
    end
  end

  assign in_ready        = (count_r < 3'd3);
  assign out_valid       = (count_r != 3'd0);
  assign out_span_kind   = queue_r[head_r].kind;
  assign out_span_begin  = queue_r[head_r].span_begin;
  assign out_span_end    = queue_r[head_r].span_end;
  assign out_last_of_run = queue_r[head_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PLAIN;
      held_r  <= 1'b0;
      pos_r   <= '0;
      last_r  <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (pop) begin
        head_r <= head_r + 2'd1;
      end
      if (accept) begin
        mode_r <= mode_nxt;
        held_r <= held_nxt;
        pos_r  <= pos_nxt;
        last_r <= last_nxt;
        tail_r <= tail_r + push_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (body_v) begin
        queue_r[tail_r] <= body_s;
      end
      if (mark_v) begin
        queue_r[tail_r + {1'b0, body_v}] <= mark_s;
      end
    end
  end

endmodule
`default_nettype wire
